FILE: rtl/ncs_pkg.sv
// Shared types, constants and saturation helpers for the natural cubic spline interpolator.
// No dependencies.
package ncs_pkg;

   localparam int MAX_KNOTS_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic KIND_SOLVE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BELOW   = 2'd1;
   localparam logic [1:0] ST_FEW     = 2'd2;
   localparam logic [1:0] ST_SPACING = 2'd3;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   // reciprocal of six scaled by 2^34, rounded up
   localparam logic [63:0] RECIP6 = 64'h00000000aaaaaaab;

   // one knot row of the working store
   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] val;
      logic signed [31:0] sp;
      logic signed [31:0] sl;
      logic signed [31:0] dg;
      logic signed [31:0] rh;
      logic signed [31:0] z;
   } row_type;

   function automatic logic signed [63:0] sx(input logic signed [31:0] v);
      logic signed [63:0] r;
      r = v;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > sx(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < sx(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // divide by six, truncating toward zero; exact for any 32-bit magnitude
   function automatic logic signed [31:0] div6(input logic signed [31:0] v);
      logic [31:0] m;
      logic [63:0] p;
      logic [31:0] q;
      m = v[31] ? 32'(-v) : 32'(v);
      p = {32'd0, m} * RECIP6;
      q = {2'b00, p[63:34]};
      return v[31] ? -$signed(q) : $signed(q);
   endfunction

endpackage

FILE: rtl/ncs_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module ncs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ncs_div.sv
// Sequential signed divider, one quotient bit per cycle, truncates toward zero and saturates.
// Depends on ncs_pkg.
module ncs_div #(
   parameter int NUM_W = 49
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [NUM_W-1:0]  num,
   input  logic signed [31:0]       den,
   output logic                     done,
   output logic signed [31:0]       quot
);
   import ncs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [31:0]            rem_ff, rem_in;
   logic [NUM_W-1:0]       qsh_ff, qsh_in;
   logic [31:0]            dmag_ff, dmag_in;
   logic                   neg_ff, neg_in;
   logic signed [31:0]     quot_ff, quot_in;

   always_comb begin
      logic [32:0]        rem_sh;
      logic [32:0]        rem_sub;
      logic signed [63:0] qv;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff, qsh_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, dmag_ff};
      qv      = 64'(qsh_ff);
      if (neg_ff) begin
         qv = -qv;
      end
      if (start) begin
         if (den == '0) begin
            if (num > 0) begin
               quot_in = SAT_MAX;
            end else if (num < 0) begin
               quot_in = SAT_MIN;
            end else begin
               quot_in = '0;
            end
            done_in = 1'b1;
         end else begin
            neg_in  = num[NUM_W-1] ^ den[31];
            qsh_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_in = den[31] ? 32'(-den) : 32'(den);
            rem_in  = '0;
            cnt_in  = CNT_W'(NUM_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (!rem_sub[32]) begin
               rem_in = rem_sub[31:0];
               qsh_in = {qsh_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               qsh_in = {qsh_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = sat32(qv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      qsh_ff  <= qsh_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/natural_cubic_spline_interpolator_top.sv
// Natural cubic spline interpolator: knot store in one RAM, shared multiplier and divider.
// Depends on ncs_pkg, ncs_ram, ncs_div.
//
// Knots are loaded one per transfer (no result) in rising position order; the knot
// flagged last_knot runs the solve and returns one report. All rows (position, value, spacing,
// slope, diagonal, right side, second derivative) sit in one RAM row per knot; every solve step is a
// read, an update through the single 32x32 multiplier or the bit-serial divider, and a write back.
// Divisions by six use a constant reciprocal multiply. Solves and queries both use the divider,
// which yields one quotient bit per cycle, and a query also walks a linear knot search.
// A new transfer is taken while the last result still waits at the output.
module natural_cubic_spline_interpolator_top #(
   parameter int MAX_KNOTS = ncs_pkg::MAX_KNOTS_DEF,
   parameter int FRAC_BITS = ncs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [ncs_pkg::DATA_W-1:0]   req_position,
   input  logic signed [ncs_pkg::DATA_W-1:0]   req_knot_value,
   input  logic                                req_last_knot,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_result_kind,
   output logic signed [ncs_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [1:0]                          rsp_status
);
   import ncs_pkg::*;

   localparam int AW = $clog2(MAX_KNOTS);
   localparam int CW = $clog2(MAX_KNOTS + 1);
   localparam int NW = 33 + FRAC_BITS;
   localparam int RW = $bits(row_type);

   typedef enum logic [4:0] {
      S_IDLE, S_RESP, S_MUL, S_DIV,
      SV_START, SA_R0, SA_NXT, SA_SL, SA_LAST,
      SB_START, SB_P0, SB_ROW, SB_D1, SB_M2, SB_D2, SB_T2, SB_WR,
      SC_RD, SC_MUL, SC_DIV, SC_WR,
      Q_P0, Q_SRCH, Q_NXT, Q_B6, Q_BQ, Q_QD, Q_Q6, Q_A, Q_A2, Q_V
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               solved_ff, solved_in;
   logic               closed_ff, closed_in;
   logic [1:0]         sstat_ff, sstat_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [31:0] x_ff, x_in;
   row_type            cur_ff, cur_in, nxt_ff, nxt_in;
   logic signed [31:0] h_ff, h_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [31:0] zn_ff, zn_in, d_ff, d_in, bq_ff, bq_in;
   logic signed [31:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               div_go_ff, div_go_in;
   logic signed [NW-1:0] div_num_ff, div_num_in;
   logic signed [31:0] div_den_ff, div_den_in;
   logic               res_kind_ff, res_kind_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_wa, ram_ra;
   row_type            ram_wd;
   logic [RW-1:0]      ram_rd_raw;
   row_type            rd;
   logic               div_done;
   logic signed [31:0] div_q;
   logic signed [31:0] fxm;

   ncs_ram #(.WIDTH(RW), .DEPTH(MAX_KNOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_raw)
   );

   ncs_div #(.NUM_W(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign rd  = row_type'(ram_rd_raw);
   assign fxm = sat32(prod_ff >>> FRAC_BITS);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      logic [CW-1:0]      c;
      logic signed [63:0] diff;
      row_type            w;
      state_in    = state_ff;
      ret_in      = ret_ff;
      cnt_in      = cnt_ff;
      solved_in   = solved_ff;
      closed_in   = closed_ff;
      sstat_in    = sstat_ff;
      idx_in      = idx_ff;
      x_in        = x_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      h_in        = h_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      zn_in       = zn_ff;
      d_in        = d_ff;
      bq_in       = bq_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      prod_in     = prod_ff;
      div_go_in   = 1'b0;
      div_num_in  = div_num_ff;
      div_den_in  = div_den_ff;
      res_kind_in = res_kind_ff;
      res_val_in  = res_val_ff;
      res_st_in   = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_st_in   = rsp_st_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_wa = idx_ff;
      ram_ra = idx_ff;
      ram_wd = cur_ff;
      c      = closed_ff ? '0 : cnt_ff;
      diff   = sx(rd.pos) - sx(cur_ff.pos);
      w      = nxt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_position;
               if (req_cmd == CMD_LOAD) begin
                  if (closed_ff) begin
                     solved_in = 1'b0;
                     closed_in = 1'b0;
                  end
                  cnt_in = c;
                  if (c < CW'(MAX_KNOTS)) begin
                     ram_we = 1'b1;
                     ram_wa = c[AW-1:0];
                     ram_wd = '{pos: req_position, val: req_knot_value,
                                sp: '0, sl: '0, dg: '0, rh: '0, z: '0};
                     cnt_in = c + 1'b1;
                  end
                  if (req_last_knot) begin
                     state_in = SV_START;
                  end
               end else if (!solved_ff) begin
                  res_kind_in = KIND_QUERY;
                  res_val_in  = '0;
                  res_st_in   = sstat_ff;
                  state_in    = S_RESP;
               end else begin
                  ram_re   = 1'b1;
                  ram_ra   = '0;
                  state_in = Q_P0;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         S_MUL: begin
            prod_in  = sx(mul_a_ff) * sx(mul_b_ff);
            state_in = ret_ff;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = ret_ff;
            end
         end
         SV_START: begin
            if (cnt_ff < CW'(2)) begin
               sstat_in = ST_FEW; solved_in = 1'b0; closed_in = 1'b1;
               res_kind_in = KIND_SOLVE; res_val_in = '0; res_st_in = ST_FEW;
               state_in = S_RESP;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = '0;
               idx_in   = '0;
               state_in = SA_R0;
            end
         end
         SA_R0: begin
            cur_in   = rd;
            ram_re   = 1'b1;
            ram_ra   = AW'(idx_ff + 1'b1);
            state_in = SA_NXT;
         end
         SA_NXT: begin
            nxt_in = rd;
            // spacing must be positive and fit in 31 bits
            if (diff[32] || diff[31] || (diff[32:0] == '0)) begin
               sstat_in = ST_SPACING; solved_in = 1'b0; closed_in = 1'b1;
               res_kind_in = KIND_SOLVE; res_val_in = '0; res_st_in = ST_SPACING;
               state_in = S_RESP;
            end else begin
               h_in       = diff[31:0];
               div_num_in = NW'(sx(rd.val) - sx(cur_ff.val)) <<< FRAC_BITS;
               div_den_in = diff[31:0];
               div_go_in  = 1'b1;
               ret_in     = SA_SL;
               state_in   = S_DIV;
            end
         end
         SA_SL: begin
            w      = cur_ff;
            w.sp   = h_ff;
            w.sl   = div_q;
            w.z    = '0;
            ram_we = 1'b1;
            ram_wd = w;
            cur_in = nxt_ff;
            idx_in = AW'(idx_ff + 1'b1);
            if (CW'(idx_ff) + CW'(2) == cnt_ff) begin
               state_in = SA_LAST;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(idx_ff + 2'd2);
               state_in = SA_NXT;
            end
         end
         SA_LAST: begin
            w      = cur_ff;
            w.z    = '0;
            ram_we = 1'b1;
            ram_wd = w;
            if (cnt_ff < CW'(3)) begin
               sstat_in = ST_OK; solved_in = 1'b1; closed_in = 1'b1;
               res_kind_in = KIND_SOLVE; res_val_in = '0; res_st_in = ST_OK;
               state_in = S_RESP;
            end else begin
               state_in = SB_START;
            end
         end
         SB_START: begin
            ram_re   = 1'b1;
            ram_ra   = '0;
            idx_in   = AW'(1);
            state_in = SB_P0;
         end
         SB_P0: begin
            cur_in   = rd;
            ram_re   = 1'b1;
            ram_ra   = idx_ff;
            state_in = SB_ROW;
         end
         SB_ROW: begin
            nxt_in = rd;
            if (idx_ff == AW'(1)) begin
               t1_in    = '0;
               t2_in    = '0;
               state_in = SB_WR;
            end else begin
               mul_a_in = cur_ff.sp;
               mul_b_in = cur_ff.sp;
               ret_in   = SB_D1;
               state_in = S_MUL;
            end
         end
         SB_D1: begin
            div_num_in = NW'(sx(fxm)) <<< FRAC_BITS;
            div_den_in = cur_ff.dg;
            div_go_in  = 1'b1;
            ret_in     = SB_M2;
            state_in   = S_DIV;
         end
         SB_M2: begin
            t1_in    = div_q;
            mul_a_in = cur_ff.sp;
            mul_b_in = cur_ff.rh;
            ret_in   = SB_D2;
            state_in = S_MUL;
         end
         SB_D2: begin
            div_num_in = NW'(sx(fxm)) <<< FRAC_BITS;
            div_den_in = cur_ff.dg;
            div_go_in  = 1'b1;
            ret_in     = SB_T2;
            state_in   = S_DIV;
         end
         SB_T2: begin
            t2_in    = div_q;
            state_in = SB_WR;
         end
         SB_WR: begin
            w.dg   = sat32(64'sd2 * (sx(nxt_ff.sp) + sx(cur_ff.sp)) - sx(t1_ff));
            w.rh   = sat32(64'sd6 * (sx(nxt_ff.sl) - sx(cur_ff.sl)) - sx(t2_ff));
            ram_we = 1'b1;
            ram_wd = w;
            cur_in = w;
            if (CW'(idx_ff) + CW'(2) == cnt_ff) begin
               zn_in    = '0;
               state_in = SC_RD;
            end else begin
               idx_in   = AW'(idx_ff + 1'b1);
               ram_re   = 1'b1;
               ram_ra   = AW'(idx_ff + 1'b1);
               state_in = SB_ROW;
            end
         end
         SC_RD: begin
            ram_re   = 1'b1;
            state_in = SC_MUL;
         end
         SC_MUL: begin
            nxt_in   = rd;
            mul_a_in = rd.sp;
            mul_b_in = zn_ff;
            ret_in   = SC_DIV;
            state_in = S_MUL;
         end
         SC_DIV: begin
            div_num_in = NW'(sx(sat32(sx(nxt_ff.rh) - sx(fxm)))) <<< FRAC_BITS;
            div_den_in = nxt_ff.dg;
            div_go_in  = 1'b1;
            ret_in     = SC_WR;
            state_in   = S_DIV;
         end
         SC_WR: begin
            w.z    = div_q;
            ram_we = 1'b1;
            ram_wd = w;
            zn_in  = div_q;
            if (idx_ff == AW'(1)) begin
               sstat_in = ST_OK; solved_in = 1'b1; closed_in = 1'b1;
               res_kind_in = KIND_SOLVE; res_val_in = '0; res_st_in = ST_OK;
               state_in = S_RESP;
            end else begin
               idx_in   = AW'(idx_ff - 1'b1);
               state_in = SC_RD;
            end
         end
         Q_P0: begin
            if (x_ff < rd.pos) begin
               res_kind_in = KIND_QUERY; res_val_in = '0; res_st_in = ST_BELOW;
               state_in = S_RESP;
            end else begin
               idx_in   = AW'(cnt_ff - CW'(2));
               ram_re   = 1'b1;
               ram_ra   = AW'(cnt_ff - CW'(2));
               state_in = Q_SRCH;
            end
         end
         Q_SRCH: begin
            cur_in = rd;
            ram_re = 1'b1;
            // walk down to the last interval whose start is not above x
            if ((idx_ff != '0) && (x_ff < rd.pos)) begin
               idx_in = AW'(idx_ff - 1'b1);
               ram_ra = AW'(idx_ff - 1'b1);
            end else begin
               ram_ra   = AW'(idx_ff + 1'b1);
               state_in = Q_NXT;
            end
         end
         Q_NXT: begin
            nxt_in   = rd;
            d_in     = sat32(sx(x_ff) - sx(cur_ff.pos));
            mul_a_in = cur_ff.sp;
            mul_b_in = sat32(sx(rd.z) + 64'sd2 * sx(cur_ff.z));
            ret_in   = Q_B6;
            state_in = S_MUL;
         end
         Q_B6: begin
            t1_in    = div6(fxm);
            state_in = Q_BQ;
         end
         Q_BQ: begin
            bq_in    = sat32(sx(cur_ff.sl) - sx(t1_ff));
            mul_a_in = d_ff;
            mul_b_in = sat32(sx(nxt_ff.z) - sx(cur_ff.z));
            ret_in   = Q_QD;
            state_in = S_MUL;
         end
         Q_QD: begin
            div_num_in = NW'(sx(fxm)) <<< FRAC_BITS;
            div_den_in = cur_ff.sp;
            div_go_in  = 1'b1;
            ret_in     = Q_Q6;
            state_in   = S_DIV;
         end
         Q_Q6: begin
            t2_in    = div6(div_q);
            state_in = Q_A;
         end
         Q_A: begin
            mul_a_in = sat32(sx(cur_ff.z >>> 1) + sx(t2_ff));
            mul_b_in = d_ff;
            ret_in   = Q_A2;
            state_in = S_MUL;
         end
         Q_A2: begin
            mul_a_in = sat32(sx(fxm) + sx(bq_ff));
            mul_b_in = d_ff;
            ret_in   = Q_V;
            state_in = S_MUL;
         end
         Q_V: begin
            res_kind_in = KIND_QUERY;
            res_val_in  = sat32(sx(cur_ff.val) + sx(fxm));
            res_st_in   = ST_OK;
            state_in    = S_RESP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         cnt_ff       <= '0;
         solved_ff    <= 1'b0;
         closed_ff    <= 1'b0;
         sstat_ff     <= ST_FEW;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         solved_ff    <= solved_in;
         closed_ff    <= closed_in;
         sstat_ff     <= sstat_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      x_ff        <= x_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      h_ff        <= h_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      zn_ff       <= zn_in;
      d_ff        <= d_in;
      bq_ff       <= bq_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= prod_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      res_kind_ff <= res_kind_in;
      res_val_ff  <= res_val_in;
      res_st_ff   <= res_st_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;

endmodule

FILE: rtl/ncs_chk.sv
// Port-level checker for the spline interpolator, bound to the top level.
// Depends on ncs_pkg and natural_cubic_spline_interpolator_top.
module ncs_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_result_kind,
   input logic signed [ncs_pkg::DATA_W-1:0]  rsp_result_value,
   input logic [1:0]                         rsp_status
);
   import ncs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
      && $stable(rsp_status) && $stable(rsp_result_kind))
      else $error("result changed while stalled");

   a_solve_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_SOLVE) |-> rsp_result_value == '0)
      else $error("solve report carries a value");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_result_value == '0)
      else $error("failed query carries a value");

   a_solve_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_SOLVE) |-> rsp_status != ST_BELOW)
      else $error("solve report with below-first-knot status");

   // out of reset: no result pending, input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle right after reset");

endmodule

bind natural_cubic_spline_interpolator_top ncs_chk u_ncs_chk (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);
